>>> src/assert_macros.svh
// assertion macros used by sliding_window_send_queue.sv
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/swsq_pkg.sv
// constants and types for the sliding window send queue
// no dependencies
package swsq_pkg;

    localparam int QUEUE_DEPTH   = 256;    // power of two
    localparam int RETRANS_DEPTH = 64;     // power of two
    localparam int PAYLOAD_BYTES = 1024;   // power of two

    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int RETRANS_AW    = $clog2(RETRANS_DEPTH);
    localparam int RETRANS_CW    = $clog2(RETRANS_DEPTH + 1);
    localparam int PAYLOAD_SHIFT = $clog2(PAYLOAD_BYTES);

    localparam int WINDOW_W      = 9;
    localparam int INFLIGHT_W    = 9;
    localparam int CMD_W         = 3;
    localparam int SLOT_W        = 48;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(16);

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE  = 3'd0,
        CMD_ACK      = 3'd1,
        CMD_SEND     = 3'd2,
        CMD_RT_PUSH  = 3'd3,
        CMD_RT_POP   = 3'd4
    } command_t;

endpackage

>>> src/sliding_window_send_queue.sv
// sliding window send queue: descriptor queue, send window, cumulative ack
// and retransmit ring; depends on swsq_pkg and assert_macros.svh
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | tuser command, tdata 112 bits
//  m_*      | out       | m_tvalid/m_tready  | tuser 2 flags, tdata 96 bits
//  cfg_*    | in        | cfg_valid/cfg_ready| window_size, 9 bits
//
// one command per cycle while s_tready is high; a result passes through the
// registered read of the slot memory and then the output register.
// reset clears pointers and counters at once; memories are not cleared.
// a stalled output holds the middle stage, and s_tready drops only when both
// the middle stage and the output register are full.
`include "assert_macros.svh"

module sliding_window_send_queue
    import swsq_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [111:0]  s_tdata,   // packet_handle, packet_length, ack_number, retrans_seq
    input  logic [2:0]    s_tuser,   // command
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,   // out_handle, out_length, inflight_count, oldest_handle, pad
    output logic [1:0]    m_tuser,   // accepted, oldest_valid
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [8:0]    cfg_data   // window_size
);

    logic [WINDOW_W-1:0]   window_reg;
    logic [31:0]           head_reg, head_next;
    logic [31:0]           tail_reg, tail_next;
    logic [31:0]           snd_ptr_reg, snd_ptr_next;
    logic [QUEUE_CW-1:0]   queued_reg, queued_next;
    logic [INFLIGHT_W-1:0] flight_reg, flight_next;
    logic [RETRANS_AW-1:0] rt_head_reg, rt_head_next;
    logic [RETRANS_AW-1:0] rt_tail_reg, rt_tail_next;
    logic [RETRANS_CW-1:0] rt_count_reg, rt_count_next;

    logic [SLOT_W-1:0]     slot_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   rt_mem [RETRANS_DEPTH];

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_acc_reg;
    logic                  s1_pkt_reg;
    logic [INFLIGHT_W-1:0] s1_inflight_reg;
    logic                  s1_oldest_valid_reg;
    logic [SLOT_W-1:0]     slot_rd_reg;
    logic [31:0]           oldest_rd_reg;
    logic [QUEUE_AW-1:0]   rt_front_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [95:0]           m_tdata_reg;
    logic [1:0]            m_tuser_reg;

    logic                  accept;
    logic                  out_free;
    logic                  s1_advance;
    command_t              cmd;
    logic [31:0]           in_handle;
    logic [15:0]           in_length;
    logic [31:0]           in_ack;
    logic [31:0]           in_seq;
    logic [31:0]           ack_m;
    logic [31:0]           ack_idx;
    logic [31:0]           freed;
    logic                  acc_c;
    logic                  pkt_c;
    logic [INFLIGHT_W-1:0] inflight_c;
    logic                  slot_wr;
    logic                  rt_wr;
    logic [QUEUE_AW-1:0]   slot_rd_addr;
    logic [QUEUE_AW-1:0]   seq_slot;
    logic [31:0]           seq_pkt;

    assign cfg_ready  = 1'b1;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_tready   = !s1_valid_reg || out_free;
    assign accept     = s_tvalid && s_tready;

    assign cmd        = command_t'(s_tuser);
    assign in_handle  = s_tdata[31:0];
    assign in_length  = s_tdata[47:32];
    assign in_ack     = s_tdata[79:48];
    assign in_seq     = s_tdata[111:80];

    // ack number rounded up to a packet index; the quotient is narrow so +1 never wraps
    assign ack_m      = in_ack - 32'd1;
    assign ack_idx    = (ack_m >> PAYLOAD_SHIFT) + 32'd1;
    assign freed      = ack_idx - head_reg;
    assign seq_pkt    = in_seq >> PAYLOAD_SHIFT;
    assign seq_slot   = seq_pkt[QUEUE_AW-1:0];

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        snd_ptr_next  = snd_ptr_reg;
        queued_next   = queued_reg;
        flight_next   = flight_reg;
        rt_head_next  = rt_head_reg;
        rt_tail_next  = rt_tail_reg;
        rt_count_next = rt_count_reg;
        acc_c         = 1'b0;
        pkt_c         = 1'b0;
        inflight_c    = '0;
        slot_wr       = 1'b0;
        rt_wr         = 1'b0;
        slot_rd_addr  = snd_ptr_reg[QUEUE_AW-1:0];
        if (accept)
        begin
            unique case (cmd)
                CMD_ENQUEUE:
                begin
                    if (queued_reg != QUEUE_CW'(QUEUE_DEPTH))
                    begin
                        slot_wr     = 1'b1;
                        tail_next   = tail_reg + 32'd1;
                        queued_next = queued_reg + QUEUE_CW'(1);
                        acc_c       = 1'b1;
                    end
                end
                CMD_ACK:
                begin
                    if (ack_idx > head_reg && ack_idx <= tail_reg)
                    begin
                        head_next   = ack_idx;
                        queued_next = queued_reg - freed[QUEUE_CW-1:0];
                        flight_next = flight_reg - freed[INFLIGHT_W-1:0];
                        inflight_c  = flight_reg - freed[INFLIGHT_W-1:0];
                        acc_c       = 1'b1;
                    end
                end
                CMD_SEND:
                begin
                    if (snd_ptr_reg != head_reg + 32'(window_reg) && snd_ptr_reg != tail_reg)
                    begin
                        snd_ptr_next = snd_ptr_reg + 32'd1;
                        flight_next  = flight_reg + INFLIGHT_W'(1);
                        pkt_c        = 1'b1;
                        acc_c        = 1'b1;
                    end
                end
                CMD_RT_PUSH:
                begin
                    if (rt_count_reg != RETRANS_CW'(RETRANS_DEPTH))
                    begin
                        rt_wr         = 1'b1;
                        rt_tail_next  = rt_tail_reg + RETRANS_AW'(1);
                        rt_count_next = rt_count_reg + RETRANS_CW'(1);
                        acc_c         = 1'b1;
                    end
                end
                CMD_RT_POP:
                begin
                    if (rt_count_reg != '0)
                    begin
                        slot_rd_addr  = rt_front_reg;
                        rt_head_next  = rt_head_reg + RETRANS_AW'(1);
                        rt_count_next = rt_count_reg - RETRANS_CW'(1);
                        pkt_c         = 1'b1;
                        acc_c         = 1'b1;
                    end
                end
                default:
                begin
                    acc_c = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (s1_advance)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= WINDOW_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            snd_ptr_reg  <= '0;
            queued_reg   <= '0;
            flight_reg   <= '0;
            rt_head_reg  <= '0;
            rt_tail_reg  <= '0;
            rt_count_reg <= '0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                window_reg <= cfg_data;
            end
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            snd_ptr_reg  <= snd_ptr_next;
            queued_reg   <= queued_next;
            flight_reg   <= flight_next;
            rt_head_reg  <= rt_head_next;
            rt_tail_reg  <= rt_tail_next;
            rt_count_reg <= rt_count_next;
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // slot memory: one write, packet read and oldest-handle read
    always_ff @(posedge clk)
    begin
        if (slot_wr)
        begin
            slot_mem[tail_reg[QUEUE_AW-1:0]] <= {in_length, in_handle};
        end
        if (accept && pkt_c)
        begin
            slot_rd_reg <= slot_mem[slot_rd_addr];
        end
        if (accept)
        begin
            // enqueue into an empty queue makes the new entry the oldest
            if (slot_wr && tail_reg[QUEUE_AW-1:0] == head_next[QUEUE_AW-1:0])
            begin
                oldest_rd_reg <= in_handle;
            end
            else
            begin
                oldest_rd_reg <= slot_mem[head_next[QUEUE_AW-1:0]][31:0];
            end
            s1_acc_reg          <= acc_c;
            s1_pkt_reg          <= pkt_c;
            s1_inflight_reg     <= inflight_c;
            s1_oldest_valid_reg <= (queued_next != '0);
        end
    end

    // retransmit ring keeps slot indexes; front entry is prefetched every cycle
    always_ff @(posedge clk)
    begin
        if (rt_wr)
        begin
            rt_mem[rt_tail_reg] <= seq_slot;
        end
        if (rt_wr && rt_tail_reg == rt_head_next)
        begin
            rt_front_reg <= seq_slot;
        end
        else
        begin
            rt_front_reg <= rt_mem[rt_head_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            m_tdata_reg[31:0]  <= s1_pkt_reg ? slot_rd_reg[31:0] : 32'd0;
            m_tdata_reg[47:32] <= s1_pkt_reg ? slot_rd_reg[47:32] : 16'd0;
            m_tdata_reg[56:48] <= s1_inflight_reg;
            m_tdata_reg[88:57] <= s1_oldest_valid_reg ? oldest_rd_reg : 32'd0;
            m_tdata_reg[95:89] <= '0;
            m_tuser_reg        <= {s1_oldest_valid_reg, s1_acc_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_IMP(a_queued_matches_ptrs, clk, rst_n, 1'b1, queued_reg == QUEUE_CW'(tail_reg - head_reg))
    `ASSERT_IMP(a_rt_count_bound, clk, rst_n, 1'b1, rt_count_reg <= RETRANS_CW'(RETRANS_DEPTH))
    `ASSERT_NEXT(a_stall_holds_beat, clk, rst_n, m_tvalid_reg && !m_tready, m_tvalid_reg && $stable(m_tdata_reg) && $stable(m_tuser_reg))

endmodule
